@@ rtl/core/domain_name_syntax_checker_unit_defines.svh @@
// assertion macros for the domain name syntax checker
`ifndef DOMAIN_NAME_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`define DOMAIN_NAME_SYNTAX_CHECKER_UNIT_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define DNSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dnsc assertion failed");

// antecedent at one edge implies consequent at the next edge
`define DNSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dnsc assertion failed");

`endif

@@ rtl/core/dnsc_pkg.sv @@
// shared types, constants and the tld lookup of the domain name syntax checker
package dnsc_pkg;

  localparam int MAX_LABEL_LEN = 63;
  localparam int TLD_MAX_CHARS = 5;
  localparam int LEN_CAP       = (MAX_LABEL_LEN + 1 > 127) ? 127 : MAX_LABEL_LEN + 1;
  localparam int LEN_W         = 7;
  localparam int HEAD_W        = 8 * TLD_MAX_CHARS;
  localparam int NUM_TLDS      = 21;

  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = 1;
  localparam int FIFO_CNT_W    = 2;

  localparam logic [1:0] LABEL_CNT_MAX = 2'd2;

  localparam logic [7:0] CHAR_DOT     = 8'h2e;
  localparam logic [7:0] CHAR_HYPHEN  = 8'h2d;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // one classified byte as it waits in the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       dot;
    logic       ldh;
    logic       hyph;
    logic       last;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // tld strings, first character in the low byte
  localparam logic [63:0] TLD_CHARS [NUM_TLDS] = '{
    64'h6d6f63,     // com
    64'h67726f,     // org
    64'h74656e,     // net
    64'h756465,     // edu
    64'h766f67,     // gov
    64'h6c696d,     // mil
    64'h6f666e69,   // info
    64'h7a6962,     // biz
    64'h656d616e,   // name
    64'h69626f6d,   // mobi
    64'h6f7270,     // pro
    64'h746e69,     // int
    64'h706f6f63,   // coop
    64'h73626f6a,   // jobs
    64'h68636574,   // tech
    64'h707061,     // app
    64'h6f69,       // io
    64'h6f63,       // co
    64'h6961,       // ai
    64'h766564,     // dev
    64'h64756f6c63  // cloud
  };

  localparam logic [3:0] TLD_LEN [NUM_TLDS] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd3,
    4'd3, 4'd4, 4'd4, 4'd4, 4'd3, 4'd2, 4'd2, 4'd2, 4'd3, 4'd5
  };

  function automatic logic head_is_tld(logic [HEAD_W-1:0] head, logic [LEN_W-1:0] len);
    logic hit;
    hit = 1'b0;
    for (int t = 0; t < NUM_TLDS; t++) begin
      if ((int'(TLD_LEN[t]) <= TLD_MAX_CHARS) && (len == LEN_W'(TLD_LEN[t])) &&
          (TLD_CHARS[t] == 64'(head))) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

@@ rtl/core/dnsc_front.sv @@
// front end: case folding and byte classification
module dnsc_front (
  input  logic           in_valid_i,
  input  logic [7:0]     char_code_i,
  input  logic           last_char_i,
  input  logic           fifo_full_i,
  output logic           in_ready_o,
  output logic           push_o,
  output dnsc_pkg::item_t item_o
);

  logic [7:0] ch;
  logic       alpha;
  logic       digit;

  always_comb begin
    ch = char_code_i;
    if (char_code_i >= dnsc_pkg::CHAR_UPPER_A && char_code_i <= dnsc_pkg::CHAR_UPPER_Z) begin
      ch = char_code_i + dnsc_pkg::CASE_OFFSET;
    end
    alpha = (ch >= dnsc_pkg::CHAR_LOWER_A) && (ch <= dnsc_pkg::CHAR_LOWER_Z);
    digit = (ch >= dnsc_pkg::CHAR_DIGIT_0) && (ch <= dnsc_pkg::CHAR_DIGIT_9);

    item_o.ch   = ch;
    item_o.dot  = (ch == dnsc_pkg::CHAR_DOT);
    item_o.hyph = (ch == dnsc_pkg::CHAR_HYPHEN);
    item_o.ldh  = alpha || digit || (ch == dnsc_pkg::CHAR_HYPHEN);
    item_o.last = last_char_i;
  end

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

endmodule

@@ rtl/core/dnsc_fifo.sv @@
// short queue of classified bytes between front and back end
module dnsc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dnsc_pkg::item_t       item_i,
  input  logic                  pop_i,
  output dnsc_pkg::item_t       item_o,
  output dnsc_pkg::fifo_status_t status_o
);

  dnsc_pkg::item_t                     mem_q [dnsc_pkg::FIFO_DEPTH];
  logic [dnsc_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [dnsc_pkg::FIFO_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [dnsc_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == dnsc_pkg::FIFO_PTR_W'(dnsc_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == dnsc_pkg::FIFO_PTR_W'(dnsc_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == dnsc_pkg::FIFO_CNT_W'(dnsc_pkg::FIFO_DEPTH));

endmodule

@@ rtl/core/dnsc_back.sv @@
// back end: label rule checking, tld match and verdict register
module dnsc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  dnsc_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            domain_valid_o
);

  logic [dnsc_pkg::LEN_W-1:0]  len_q, len_d;
  logic                        hy_q, hy_d;
  logic [dnsc_pkg::HEAD_W-1:0] head_q, head_d;
  logic                        tld_q, tld_d;
  logic [1:0]                  cnt_q, cnt_d;
  logic                        err_q, err_d;
  logic                        out_valid_q, out_valid_d;
  logic                        verdict_q, verdict_d;

  logic [dnsc_pkg::LEN_W-1:0]  len_a;
  logic                        hy_a;
  logic [dnsc_pkg::HEAD_W-1:0] head_a;
  logic                        err_a;
  logic                        verdict;

  // a final item may only leave the queue when the verdict register can take it
  assign pop_o = item_valid_i && (!item_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    len_a  = len_q;
    hy_a   = hy_q;
    head_a = head_q;
    err_a  = err_q;
    if (!item_i.dot) begin
      if (!item_i.ldh ||
          (item_i.hyph && (len_q == '0 || hy_q)) ||
          (len_q >= dnsc_pkg::LEN_W'(dnsc_pkg::MAX_LABEL_LEN))) begin
        err_a = 1'b1;
      end
      for (int i = 0; i < dnsc_pkg::TLD_MAX_CHARS; i++) begin
        if (len_q == dnsc_pkg::LEN_W'(i)) begin
          head_a[8*i +: 8] = item_i.ch;
        end
      end
      if (len_q < dnsc_pkg::LEN_W'(dnsc_pkg::LEN_CAP)) begin
        len_a = len_q + 1'b1;
      end
      hy_a = item_i.hyph;
    end

    len_d  = len_a;
    hy_d   = hy_a;
    head_d = head_a;
    err_d  = err_a;
    tld_d  = tld_q;
    cnt_d  = cnt_q;

    // a dot or the end of the name closes a non-empty label
    if ((item_i.dot || item_i.last) && len_a != '0) begin
      err_d  = err_a || hy_a;
      tld_d  = dnsc_pkg::head_is_tld(head_a, len_a);
      cnt_d  = (cnt_q < dnsc_pkg::LABEL_CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
      len_d  = '0;
      hy_d   = 1'b0;
      head_d = '0;
    end

    verdict = (cnt_d == dnsc_pkg::LABEL_CNT_MAX) && !err_d && tld_d;

    if (item_i.last) begin
      len_d  = '0;
      hy_d   = 1'b0;
      head_d = '0;
      err_d  = 1'b0;
      tld_d  = 1'b0;
      cnt_d  = '0;
    end

    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    if (pop_o && item_i.last) begin
      out_valid_d = 1'b1;
      verdict_d   = verdict;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      hy_q        <= 1'b0;
      head_q      <= '0;
      tld_q       <= 1'b0;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        len_q  <= len_d;
        hy_q   <= hy_d;
        head_q <= head_d;
        tld_q  <= tld_d;
        cnt_q  <= cnt_d;
        err_q  <= err_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign out_valid_o    = out_valid_q;
  assign domain_valid_o = verdict_q;

endmodule

@@ rtl/core/domain_name_syntax_checker_unit.sv @@
// top level of the domain name syntax checker
// Usage: the name enters one byte per transfer on the input channel
// (in_valid_i / in_ready_o, char_code_i, last_char_i); last_char_i marks the
// final byte. Exactly one verdict per name leaves on the output channel
// (out_valid_o / out_ready_i, domain_valid_o), none for the other bytes.
// Path: the final byte is written into the two-entry queue when it transfers;
// the back end moves it through the label checker into the verdict register
// as soon as that register can take it, and the verdict is offered from there.
// Throughput: one byte per cycle while no final byte is held (see Stall);
// the back end updates the label state and compares the tld for each byte
// it pops; the front end takes a byte whenever the queue has room.
// Stall: while a verdict waits in its register, the back end keeps working
// on the next name's bytes and only holds the next final byte; the queue
// then fills and in_ready_o drops.
// Reset: rst_ni clears the queue, all label state and out_valid_o; the verdict
// value register has no reset. The block takes bytes once reset is released.
`include "domain_name_syntax_checker_unit_defines.svh"

module domain_name_syntax_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       domain_valid_o
);

  dnsc_pkg::item_t        front_item;
  dnsc_pkg::item_t        fifo_item;
  dnsc_pkg::fifo_status_t fifo_status;
  logic                   push;
  logic                   pop;

  dnsc_front u_front (
    .in_valid_i  (in_valid_i),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .fifo_full_i (fifo_status.full),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .item_o      (front_item)
  );

  dnsc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (fifo_item),
    .status_o (fifo_status)
  );

  dnsc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (!fifo_status.empty),
    .item_i         (fifo_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .domain_valid_o (domain_valid_o)
  );

  `DNSC_ASSERT(a_queue_state, clk_i, rst_ni, !(fifo_status.empty && fifo_status.full))
  `DNSC_ASSERT(a_no_pop_empty, clk_i, rst_ni, !pop || !fifo_status.empty)
  `DNSC_ASSERT(a_verdict_not_lost, clk_i, rst_ni,
    !(pop && fifo_item.last) || !out_valid_o || out_ready_i)
  `DNSC_ASSERT_NEXT(a_last_gives_verdict, clk_i, rst_ni, pop && fifo_item.last, out_valid_o)

endmodule
